// ===== design/mavg_pkg.sv =====
package mavg_pkg;

  // Fixed widths of the stream fields and the configuration port
  localparam int FIELD_W     = 32;
  localparam int WSIZE_W     = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = WSIZE_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTED_MODE = 1'b1;

  // Register reset values
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd4;
  localparam logic               WMODE_RESET = 1'b0;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DIV  = 4'b0100,
    S_LOAD = 4'b1000
  } state_e;

endpackage

// ===== design/moving_average_filter_unit.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid_i/tready_o      tdata: sample_value, sample_tag
// m_axis    out  m_axis_tvalid_o/tready_i      tdata: average_value, average_tag
// cfg       in   cfg_we_i (no wait)            cfg_idx_i, cfg_wdata_i
//
// One request at a time: accept, ring scan newest to oldest (one synchronous
// read a cycle over the effective window), radix-2 divide (NUM_W = 46 by
// default), load; the next sample is taken only after the load.
// w is the effective window size. Short windows finish in the accept cycle.
// Reset clears fill count, ring pointer, registers and control, not the ring.
// A full output register holds the load cycle; a waiting result lets a sample in.
module moving_average_filter_unit #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [mavg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mavg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // sample stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [2*mavg_pkg::FIELD_W-1:0]      s_axis_tdata_i,  // [31:0] sample_value, [63:32] sample_tag
  // average stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [2*mavg_pkg::FIELD_W-1:0]      m_axis_tdata_o   // [31:0] average_value, [63:32] average_tag
);

  import mavg_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);              // ring address
  localparam int CW = $clog2(MAX_WINDOW + 1);          // sample counts
  localparam int DW = 2 * CW;                          // divisor
  localparam int TW = SAMPLE_BITS + CW;                // plain sum
  localparam int NW = SAMPLE_BITS + 2 * CW;            // weighted sum / dividend
  localparam int SW = (NW + 1 > 33) ? NW + 1 : 33;     // signed quotient for clamping
  localparam logic signed [SW-1:0] AvgMax = SW'(32'sh7fff_ffff);
  localparam logic signed [SW-1:0] AvgMin = SW'(32'sh8000_0000);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WSIZE_W-1:0] wsize_q;
  logic               wmode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= WSIZE_RESET;
      wmode_q <= WMODE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW_SIZE:   wsize_q <= cfg_wdata_i[WSIZE_W-1:0];
        REG_WEIGHTED_MODE: wmode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Effective window: zero acts as one, oversize clamps to the ring depth
  logic [CW-1:0] w_eff;
  logic [DW-1:0] tri_prod;
  logic [DW-1:0] den;

  always_comb begin
    if (wsize_q == '0) begin
      w_eff = CW'(1);
    end else if (32'(wsize_q) > MAX_WINDOW) begin
      w_eff = CW'(MAX_WINDOW);
    end else begin
      w_eff = CW'(wsize_q);
    end
  end

  assign tri_prod = DW'(w_eff) * (DW'(w_eff) + DW'(1));
  assign den      = wmode_q ? (tri_prod >> 1) : DW'(w_eff);

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic                   in_fire;
  logic signed [63:0]     sample_ext;
  logic [SAMPLE_BITS-1:0] sample_st;
  logic [FIELD_W-1:0]     in_tag;
  logic [CW-1:0]          fill_q, fill_d;
  logic [AW-1:0]          wpos_q, wpos_d;
  logic                   result_due;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // keep the low SAMPLE_BITS of the sign-extended sample
  assign sample_ext = 64'(signed'(s_axis_tdata_i[FIELD_W-1:0]));
  assign sample_st  = sample_ext[SAMPLE_BITS-1:0];
  assign in_tag     = s_axis_tdata_i[2*FIELD_W-1:FIELD_W];

  assign fill_d     = (fill_q < CW'(MAX_WINDOW)) ? fill_q + 1'b1 : fill_q;
  assign wpos_d     = (wpos_q == AW'(MAX_WINDOW - 1)) ? '0 : wpos_q + 1'b1;
  assign result_due = (fill_d >= w_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      wpos_q <= '0;
    end else if (in_fire) begin
      fill_q <= fill_d;
      wpos_q <= wpos_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample ring: one write port (accept), one registered read port (scan)
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rdata_q;
  logic [AW-1:0]          rd_addr_q, rd_addr_d;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ring[wpos_q] <= sample_st;
    end
    rdata_q <= ring[rd_addr_q];
  end

  // ---------------------------------------------------------------------------
  // Scan: newest to oldest. Suffix sum T gives the plain sum; adding every
  // partial T into W gives weight 1 on the oldest up to w on the newest.
  // Writes only happen while idle, so a read never meets a pending write.
  // ---------------------------------------------------------------------------
  logic [CW-1:0]          rd_left_q, rd_left_d;
  logic                   rvalid_q, rvalid_d;
  logic signed [TW-1:0]   sum_q, sum_d;
  logic signed [NW-1:0]   wsum_q, wsum_d;
  logic [DW-1:0]          den_q;
  logic [FIELD_W-1:0]     tag_q;
  logic                   neg_q;
  logic                   scan_done;

  assign scan_done = (state_q == S_SCAN) && (rd_left_q == '0) && !rvalid_q;

  // dividend magnitude and sign
  logic signed [NW-1:0] num;
  logic                 num_neg;
  logic [NW-1:0]        num_mag;

  assign num     = wmode_q ? wsum_q : NW'(sum_q);
  assign num_neg = num[NW-1];
  assign num_mag = num_neg ? (~num + 1'b1) : num;

  // ---------------------------------------------------------------------------
  // Divider
  // ---------------------------------------------------------------------------
  logic          div_done;
  logic [NW-1:0] quo;

  mavg_div #(
    .NUM_W (NW),
    .DEN_W (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_done),
    .dividend_i (num_mag),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // restore sign (truncation toward zero) and clamp to 32 bits
  logic signed [NW:0]    quo_s;
  logic signed [SW-1:0]  quo_ext;
  logic [FIELD_W-1:0]    avg;

  assign quo_s   = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign quo_ext = SW'(quo_s);

  always_comb begin
    if (quo_ext > AvgMax) begin
      avg = FIELD_W'(AvgMax);
    end else if (quo_ext < AvgMin) begin
      avg = FIELD_W'(AvgMin);
    end else begin
      avg = quo_ext[FIELD_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic               out_valid_q;
  logic [FIELD_W-1:0] out_value_q;
  logic [FIELD_W-1:0] out_tag_q;
  logic               out_free;
  logic               out_load;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign out_load = (state_q == S_LOAD) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= avg;
      out_tag_q   <= tag_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_tag_q, out_value_q};

  // ---------------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    rd_addr_d = rd_addr_q;
    rd_left_d = rd_left_q;
    rvalid_d  = 1'b0;
    sum_d     = sum_q;
    wsum_d    = wsum_q;

    if (rvalid_q) begin
      sum_d  = sum_q + TW'(signed'(rdata_q));
      wsum_d = wsum_q + NW'(sum_d);
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire && result_due) begin
          state_d   = S_SCAN;
          rd_addr_d = wpos_q;
          rd_left_d = w_eff;
          sum_d     = '0;
          wsum_d    = '0;
        end
      end
      S_SCAN: begin
        if (rd_left_q != '0) begin
          rvalid_d  = 1'b1;
          rd_left_d = rd_left_q - 1'b1;
          rd_addr_d = (rd_addr_q == '0) ? AW'(MAX_WINDOW - 1) : rd_addr_q - 1'b1;
        end else if (!rvalid_q) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_left_q <= '0;
      rvalid_q  <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      state_q   <= state_d;
      rd_left_q <= rd_left_d;
      rvalid_q  <= rvalid_d;
      rd_addr_q <= rd_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    wsum_q <= wsum_d;
    if (in_fire) begin
      den_q <= den;
      tag_q <= in_tag;
    end
    if (scan_done) begin
      neg_q <= num_neg;
    end
  end

endmodule

// ===== design/mavg_div.sv =====
module mavg_div #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;

  // Restoring division, one quotient bit per cycle, MSB first
  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      rem_d  = '0;
      num_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[DEN_W]) begin
        rem_d = diff[DEN_W-1:0];
        num_d = {num_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DEN_W-1:0];
        num_d = {num_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

// ===== sim/mavg_checker.sv =====
`timescale 1ns / 1ps

module mavg_checker #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mavg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mavg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  input  logic [2*mavg_pkg::FIELD_W-1:0]  s_axis_tdata_i,   // [31:0] sample_value, [63:32] sample_tag
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  input  logic [2*mavg_pkg::FIELD_W-1:0]  m_axis_tdata_i,   // [31:0] average_value, [63:32] average_tag
  output int                              mismatch_count_o,
  output int                              averages_due_o,
  output int                              averages_checked_o
);

  import mavg_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic [FIELD_W-1:0] tag;
  } average_t;

  // mirror of the filter state
  logic signed [FIELD_W-1:0] sample_ring [MAX_WINDOW];
  int                        samples_held;
  int                        ring_wr_pos;
  logic [WSIZE_W-1:0]        window_len;
  logic                      weighted;

  average_t expected_averages [$];

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count_o++;
  endtask

  // store the sample, then queue the window average if the window is full
  task automatic take_sample(input logic [FIELD_W-1:0] value, input logic [FIELD_W-1:0] tag);
    int       span;
    int       slot;
    longint   weighted_sum;
    longint   divisor;
    longint   quotient;
    average_t due;
    sample_ring[ring_wr_pos] = value;
    ring_wr_pos = (ring_wr_pos + 1) % MAX_WINDOW;
    if (samples_held < MAX_WINDOW) samples_held++;
    span = int'(window_len);
    if (span < 1) span = 1;            // size zero acts as one
    if (span > MAX_WINDOW) span = MAX_WINDOW;
    if (samples_held < span) return;   // window still short: no average
    weighted_sum = 0;
    for (int i = 0; i < span; i++) begin
      slot = (ring_wr_pos - span + i + MAX_WINDOW) % MAX_WINDOW;  // oldest first
      weighted_sum += (weighted ? longint'(i + 1) : longint'(1)) * longint'(sample_ring[slot]);
    end
    divisor = weighted ? longint'(span * (span + 1) / 2) : longint'(span);
    quotient = weighted_sum / divisor;  // signed divide truncates toward zero
    due.value = quotient[FIELD_W-1:0];
    due.tag = tag;
    expected_averages = {expected_averages, due};
  endtask

  task automatic check_average(input logic [2*FIELD_W-1:0] beat);
    average_t want;
    if (expected_averages.size() == 0) begin
      report_mismatch($sformatf("average %h tag %h with none due", beat[31:0], beat[63:32]));
      return;
    end
    want = expected_averages.pop_front();
    averages_checked_o++;
    if (beat[31:0] !== want.value)
      report_mismatch($sformatf("average_value %h, want %h (tag %h)",
                                beat[31:0], want.value, want.tag));
    if (beat[63:32] !== want.tag)
      report_mismatch($sformatf("average_tag %h, want %h", beat[63:32], want.tag));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_held = 0;
      ring_wr_pos = 0;
      window_len = WSIZE_RESET;
      weighted = WMODE_RESET;
      expected_averages.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_average(m_axis_tdata_i);
      if (s_axis_tvalid_i && s_axis_tready_i)
        take_sample(s_axis_tdata_i[FIELD_W-1:0], s_axis_tdata_i[2*FIELD_W-1:FIELD_W]);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WINDOW_SIZE:   window_len = cfg_wdata_i;
          REG_WEIGHTED_MODE: weighted = cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
    averages_due_o <= expected_averages.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mavg_pkg::*;

  localparam int RANDOM_SAMPLES = 400;
  // longest busy stretch: 64-deep scan, 46-step divide, output load
  localparam int TAIL_CYCLES    = 130;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [2*FIELD_W-1:0]  s_axis_tdata = '0;   // [31:0] sample_value, [63:32] sample_tag
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [2*FIELD_W-1:0]  m_axis_tdata;        // [31:0] average_value, [63:32] average_tag

  int mismatch_count;
  int averages_due;
  int averages_checked;

  int samples_sent = 0;
  int settings_used = 0;
  int ready_hold = 0;
  int ready_gap;
  bit quiet = 1'b0;   // set: no idling on either side

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  moving_average_filter_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  mavg_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .s_axis_tvalid_i    (s_axis_tvalid),
    .s_axis_tready_i    (s_axis_tready),
    .s_axis_tdata_i     (s_axis_tdata),
    .m_axis_tvalid_i    (m_axis_tvalid),
    .m_axis_tready_i    (m_axis_tready),
    .m_axis_tdata_i     (m_axis_tdata),
    .mismatch_count_o   (mismatch_count),
    .averages_due_o     (averages_due),
    .averages_checked_o (averages_checked)
  );

  // idle length: mostly none or short, now and then long
  function automatic int draw_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sample mix: extremes, small Q16.16 values, full-range noise
  function automatic logic [FIELD_W-1:0] draw_sample();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return 32'h7FFF_FFFF;
    if (roll < 8) return 32'h8000_0000;
    if (roll < 11) return 32'hFFFF_FFFF;
    if (roll < 13) return 32'h0000_0001;
    if (roll < 15) return 32'h0000_0000;
    if (roll < 45) return 32'($urandom_range(0, 2000 << 16)) - 32'(1000 << 16);
    return $urandom();
  endfunction

  // mostly short windows, now and then long ones, zero and oversize
  function automatic logic [WSIZE_W-1:0] pick_window();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return WSIZE_W'($urandom_range(1, 8));
    if (roll < 70) return WSIZE_W'($urandom_range(9, 32));
    if (roll < 80) return WSIZE_W'($urandom_range(33, 64));
    if (roll < 90) return WSIZE_W'($urandom_range(65, 127));
    return '0;
  endfunction

  // receiver: tready redrawn whenever a hold-off runs out
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_gap = draw_gap();
      m_axis_tready <= (ready_gap == 0);
      ready_hold <= ready_gap;
    end
  end

  // one sample request; valid stays high into the next call when no gap is drawn
  task automatic push_sample(input logic [FIELD_W-1:0] value, input logic [FIELD_W-1:0] tag);
    int   gap;
    logic taken;
    gap = draw_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {tag, value};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop the sample stream and wait until every due average is out
  task automatic drain_averages(input int tail);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (averages_due != 0);
    repeat (tail) @(posedge clk);
  endtask

  // new setting; upper bits of the mode write are junk, only bit 0 counts
  task automatic apply_setting(input logic [WSIZE_W-1:0] size, input logic mode);
    drain_averages(8);   // short windows finish in the accept cycle
    write_reg(REG_WINDOW_SIZE, size);
    write_reg(REG_WEIGHTED_MODE, {(CFG_DATA_W-1)'($urandom()), mode});
    settings_used++;
  endtask

  initial begin
    logic [WSIZE_W-1:0] size;
    logic               mode;
    int                 burst;
    int                 phase_no;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: window of 4, plain average
    // fill with max, then min: the first and last averages land exactly on the extreme
    push_sample(32'h7FFF_FFFF, 32'h0000_0000);
    push_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_sample(32'h7FFF_FFFF, 32'h0000_0000);
    push_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    repeat (4) push_sample(32'h8000_0000, $urandom());
    // all-ones samples then one: the last sum is just below zero, truncation toward zero
    push_sample(32'hFFFF_FFFF, 32'hA5A5_5A5A);
    push_sample(32'hFFFF_FFFF, 32'h5A5A_A5A5);
    push_sample(32'hFFFF_FFFF, $urandom());
    push_sample(32'h0000_0001, $urandom());

    // size zero acts as one, weighted with a divisor of one
    apply_setting('0, 1'b1);
    push_sample(32'h8000_0000, 32'hFFFF_FFFF);
    push_sample(32'h7FFF_FFFF, 32'h0000_0000);
    push_sample(32'hFFFF_FFFF, $urandom());

    // weighted pairs: weights 1 and 2 over a divisor of 3
    apply_setting(7'd2, 1'b1);
    push_sample(32'hFFFF_FFFF, $urandom());
    push_sample(32'h0000_0000, $urandom());
    push_sample(32'hFFFF_FFFE, $urandom());
    push_sample(32'h7FFF_FFFF, $urandom());
    push_sample(32'h8000_0000, $urandom());

    // random phases: the first ones pin the full-depth and oversize windows
    phase_no = 0;
    while (samples_sent < 20 + RANDOM_SAMPLES) begin
      case (phase_no)
        0: begin size = 7'd64;  mode = 1'b1; end
        1: begin size = 7'd127; mode = 1'b0; end
        2: begin size = 7'd127; mode = 1'b1; end
        default: begin size = pick_window(); mode = 1'($urandom_range(0, 1)); end
      endcase
      burst = (phase_no < 3) ? 40 : $urandom_range(8, 30);
      apply_setting(size, mode);
      quiet = (phase_no % 5 == 3);
      repeat (burst) push_sample(draw_sample(), $urandom());
      quiet = 1'b0;
      phase_no++;
    end

    drain_averages(TAIL_CYCLES);

    $display("covered %0d samples over %0d window settings (sizes 0 to 127, both modes)",
             samples_sent, settings_used);
    $display("%0d averages checked", averages_checked);
    if (mismatch_count == 0 && averages_due == 0) begin
      $display("moving_average_filter_unit regression: pass");
    end else begin
      $display("moving_average_filter_unit regression: fail");
    end
    $finish;
  end

  // watchdog, well beyond the slowest clean run
  initial begin
    #5_000_000;
    $display("moving_average_filter_unit regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mavg_pkg.sv
design/mavg_div.sv
design/moving_average_filter_unit.sv
sim/mavg_checker.sv
sim/testbench.sv
